[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL of the heading and centre block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DAHC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DAHC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/dahc_pkg.sv]
`timescale 1ns / 1ps
package dahc_pkg;

	localparam int XY_W    = 63;
	localparam int Z_W     = 34;
	localparam int IDX_W   = 6;
	localparam int COORD_W = 35;
	localparam int PROD_W  = 66;

	localparam logic signed [XY_W-1:0] GAIN_INV = XY_W'(64'sd652032874);
	localparam logic signed [35:0]     ONE_Q30  = 36'sd1073741824;
	localparam logic signed [PROD_W-1:0] HALF_Q30 = PROD_W'(64'sd536870912);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAT,
		ST_LON_LOAD,
		ST_LON,
		ST_MUL,
		ST_ATAN_LOAD,
		ST_ATAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic             vec_mode;
		logic [IDX_W-1:0] idx;
	} cordic_cmd_t;

	function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			6'd0:  r = 34'sd536870912;
			6'd1:  r = 34'sd316933406;
			6'd2:  r = 34'sd167458907;
			6'd3:  r = 34'sd85004756;
			6'd4:  r = 34'sd42667331;
			6'd5:  r = 34'sd21354465;
			6'd6:  r = 34'sd10679838;
			6'd7:  r = 34'sd5340245;
			6'd8:  r = 34'sd2670163;
			6'd9:  r = 34'sd1335087;
			6'd10: r = 34'sd667544;
			6'd11: r = 34'sd333772;
			6'd12: r = 34'sd166886;
			6'd13: r = 34'sd83443;
			6'd14: r = 34'sd41722;
			6'd15: r = 34'sd20861;
			6'd16: r = 34'sd10430;
			6'd17: r = 34'sd5215;
			6'd18: r = 34'sd2608;
			6'd19: r = 34'sd1304;
			6'd20: r = 34'sd652;
			6'd21: r = 34'sd326;
			6'd22: r = 34'sd163;
			6'd23: r = 34'sd81;
			6'd24: r = 34'sd41;
			6'd25: r = 34'sd20;
			6'd26: r = 34'sd10;
			6'd27: r = 34'sd5;
			6'd28: r = 34'sd3;
			6'd29: r = 34'sd1;
			6'd30: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clamp a rounded Q30 value to the closed range of plus and minus one.
	function automatic logic signed [31:0] clamp_q30(input logic signed [XY_W-1:0] v);
		logic signed [31:0] r;
		if (v > XY_W'(ONE_Q30)) begin
			r = 32'(ONE_Q30);
		end else if (v < -XY_W'(ONE_Q30)) begin
			r = -32'(ONE_Q30);
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[hdl/dahc_cordic.sv]
`timescale 1ns / 1ps
module dahc_cordic (
	input  logic                                 clk,
	input  dahc_pkg::cordic_cmd_t                cmd,
	input  logic signed [dahc_pkg::XY_W-1:0]     x_init,
	input  logic signed [dahc_pkg::XY_W-1:0]     y_init,
	input  logic signed [dahc_pkg::Z_W-1:0]      z_init,
	output logic signed [dahc_pkg::XY_W-1:0]     x,
	output logic signed [dahc_pkg::XY_W-1:0]     y,
	output logic signed [dahc_pkg::Z_W-1:0]      z
);
	import dahc_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q, tx, ty;
	logic signed [Z_W-1:0]  z_q, ang;
	logic                   dpos;

	// Rotation mode turns towards zero angle, vectoring mode towards zero y.
	always_comb begin
		tx   = y_q >>> cmd.idx;
		ty   = x_q >>> cmd.idx;
		ang  = atan_entry(cmd.idx);
		dpos = cmd.vec_mode ? y_q[XY_W-1] : !z_q[Z_W-1];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (cmd.step) begin
			if (dpos) begin
				x_q <= x_q - tx;
				y_q <= y_q + ty;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + tx;
				y_q <= y_q - ty;
				z_q <= z_q + ang;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
endmodule

[hdl/dual_antenna_heading_center_top.sv]
`timescale 1ns / 1ps
// Dual-antenna heading and centre. Each input transaction carries a fix from
// antenna one or two (latitude and longitude as binary angles, 2^31 being 180
// degrees). The fix is turned into spherical Cartesian millimetres with the
// radius in register 0 (byte address 0, 33 bits, reset 6371000000), replaces
// the stored position of that antenna, and one output transaction follows with
// the midpoint of both stored antennas and the heading atan2(dx, dy) of the
// baseline from antenna one to antenna two. An antenna never written sits at
// the origin. A transaction passes through the single CORDIC iteration unit,
// which runs three passes in turn (sine and cosine of latitude, of longitude,
// then the heading), and through one shared multiplier used for five
// products; in_stall stays high from acceptance until the result has been
// handed over to the output register.
module dual_antenna_heading_center_top #(
	parameter int CORDIC_STEPS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               antenna_select,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] longitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [33:0] center_x,
	output logic signed [33:0] center_y,
	output logic signed [33:0] center_z,
	output logic signed [31:0] heading
);
	import dahc_pkg::*;
	`include "assert_macros.svh"

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);
	localparam logic [2:0]       MUL_LAST  = 3'd5;

	// Configuration: a single radius register, decoded on address bit 3.
	logic [32:0] radius_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[3];
	assign prdata = paddr[3] ? 64'd0 : {31'd0, radius_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 33'd6371000000;
		end else if (cfg_wr) begin
			radius_q <= pwdata[32:0];
		end
	end

	// Sequencer state.
	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       mcnt_q;
	logic             in_acc, out_free;
	cordic_cmd_t      cmd;

	// Captured transaction and intermediate values.
	logic               sel_q, flip_lat_q, flip_lon_q, zero_base_q;
	logic signed [31:0] lon_q, slat_q, clat_q, slon_q, cc_q, cs_q;

	// Stored antenna positions, cleared by reset to the origin.
	logic signed [COORD_W-1:0] ant1_q [3];
	logic signed [COORD_W-1:0] ant2_q [3];

	// CORDIC load values.
	logic signed [XY_W-1:0] x_init, y_init, cx, cy;
	logic signed [Z_W-1:0]  z_init, cz;
	logic signed [31:0]     ang_src;
	logic                   ang_flip;
	logic signed [35:0]     dx, dy;
	logic signed [XY_W-1:0] vx, vy;

	// Shared multiplier and rounding.
	logic signed [33:0]       mul_a;
	logic signed [31:0]       mul_b;
	logic signed [PROD_W-1:0] prod_q, prod_rnd;
	logic signed [35:0]       prod_sh;
	logic signed [31:0]       q30_res;

	// Output registers and the centre held until the result is free to go.
	logic signed [33:0] ctr_x_q, ctr_y_q, ctr_z_q;
	logic signed [33:0] out_x_q, out_y_q, out_z_q;
	logic signed [31:0] out_h_q;
	logic               out_valid_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	dahc_cordic u_cordic (
		.clk    (clk),
		.cmd    (cmd),
		.x_init (x_init),
		.y_init (y_init),
		.z_init (z_init),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	// Angles in the left half plane are turned by 180 degrees first and the
	// results negated afterwards.
	always_comb begin
		ang_src  = (state_q == ST_IDLE) ? latitude : lon_q;
		ang_flip = ang_src[30] ^ ang_src[31];
		dx       = 36'(ant2_q[0]) - 36'(ant1_q[0]);
		dy       = 36'(ant2_q[1]) - 36'(ant1_q[1]);
		vx       = XY_W'(dy) <<< 24;
		vy       = XY_W'(dx) <<< 24;
		if (state_q == ST_ATAN_LOAD) begin
			// Vectoring starts in the right half plane; a negative x is
			// mirrored and the angle starts at 180 degrees.
			if (vx < 0) begin
				x_init = -vx;
				y_init = -vy;
				z_init = Z_W'(64'sd2147483648);
			end else begin
				x_init = vx;
				y_init = vy;
				z_init = '0;
			end
		end else begin
			x_init = GAIN_INV;
			y_init = '0;
			z_init = Z_W'(signed'({ang_src[31] ^ ang_flip, ang_src[30:0]}));
		end
	end

	// Next state and unit control.
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.vec_mode = (state_q == ST_ATAN);
		cmd.idx      = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.load = 1'b1;
					state_d  = ST_LAT;
				end
			end
			ST_LAT: begin
				cmd.step = 1'b1;
				if (idx_q == LAST_STEP) begin
					state_d = ST_LON_LOAD;
				end
			end
			ST_LON_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_LON;
			end
			ST_LON: begin
				cmd.step = 1'b1;
				if (idx_q == LAST_STEP) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mcnt_q == MUL_LAST) begin
					state_d = ST_ATAN_LOAD;
				end
			end
			ST_ATAN_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ATAN;
			end
			ST_ATAN: begin
				cmd.step = 1'b1;
				if (idx_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			mcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= cmd.step ? ((idx_q == LAST_STEP) ? '0 : idx_q + 1'b1) : '0;
			mcnt_q  <= (state_q == ST_MUL && mcnt_q != MUL_LAST) ? mcnt_q + 1'b1 : '0;
		end
	end

	// Multiplier schedule: cos.cos, cos.sin, then the radius times each of
	// the three unit vector components. Each product is registered and used in the next multiply step.
	// The longitude cosine is taken straight from the CORDIC unit, which
	// still holds it in the first multiply cycle.
	always_comb begin
		case (mcnt_q)
			3'd0: begin mul_a = 34'(clat_q); mul_b = clamp_q30(flip_lon_q ? -cx : cx); end
			3'd1: begin mul_a = 34'(clat_q); mul_b = slon_q; end
			3'd2: begin mul_a = {1'b0, radius_q}; mul_b = cc_q; end
			3'd3: begin mul_a = {1'b0, radius_q}; mul_b = cs_q; end
			3'd4: begin mul_a = {1'b0, radius_q}; mul_b = slat_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod_rnd = prod_q + HALF_Q30;
		prod_sh  = prod_rnd[65:30];
		q30_res  = clamp_q30(XY_W'(prod_sh));
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Datapath captures.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sel_q      <= antenna_select;
			lon_q      <= longitude;
			flip_lat_q <= ang_flip;
		end
		if (state_q == ST_LON_LOAD) begin
			slat_q     <= clamp_q30(flip_lat_q ? -cy : cy);
			clat_q     <= clamp_q30(flip_lat_q ? -cx : cx);
			flip_lon_q <= ang_flip;
		end
		if (state_q == ST_MUL && mcnt_q == 3'd0) begin
			slon_q <= clamp_q30(flip_lon_q ? -cy : cy);
		end
		if (state_q == ST_MUL && mcnt_q == 3'd1) begin
			cc_q <= q30_res;
		end
		if (state_q == ST_MUL && mcnt_q == 3'd2) begin
			cs_q <= q30_res;
		end
		if (state_q == ST_ATAN_LOAD) begin
			ctr_x_q     <= 34'((36'(ant1_q[0]) + 36'(ant2_q[0])) >>> 1);
			ctr_y_q     <= 34'((36'(ant1_q[1]) + 36'(ant2_q[1])) >>> 1);
			ctr_z_q     <= 34'((36'(ant1_q[2]) + 36'(ant2_q[2])) >>> 1);
			zero_base_q <= (dx == 0) && (dy == 0);
		end
	end

	// Antenna store: the shared multiplier results land in the selected row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ant1_q[k] <= '0;
				ant2_q[k] <= '0;
			end
		end else if (state_q == ST_MUL && mcnt_q >= 3'd3) begin
			if (sel_q) begin
				ant2_q[2'(mcnt_q - 3'd3)] <= COORD_W'(prod_sh);
			end else begin
				ant1_q[2'(mcnt_q - 3'd3)] <= COORD_W'(prod_sh);
			end
		end
	end

	// Output register: a result waits here while the next fix is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_x_q <= ctr_x_q;
			out_y_q <= ctr_y_q;
			out_z_q <= ctr_z_q;
			out_h_q <= zero_base_q ? 32'sd0 : cz[31:0];
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = out_x_q;
	assign center_y  = out_y_q;
	assign center_z  = out_z_q;
	assign heading   = out_h_q;

	`DAHC_ASSERT(a_busy_after_accept, in_acc |=> in_stall, "input taken while busy")
	`DAHC_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result raised outside the final state")
	`DAHC_ASSERT(a_no_overwrite, (out_valid_q && out_stall) |=> $stable(out_h_q), "held result overwritten")
	`DAHC_ASSERT_ALWAYS(a_step_range, idx_q <= LAST_STEP, "CORDIC step count out of range")
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the dual-antenna heading and centre block.
// Fixes are queued by the initial block, sent by a clocked driver in bursts
// with random gaps, and each accepted transaction updates a local model of
// both antenna positions. The model's midpoint and heading are held in a
// queue. A clocked monitor with its own stall pattern checks every output
// transaction against the oldest entry in that queue. The sphere radius is
// rewritten between phases, only while the block is idle.
module tb_top;
	import dahc_pkg::*;

	localparam int STEPS      = 32;
	localparam int LATENCY    = 3 * STEPS + 11;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [3:0] ADDR_RADIUS = 4'd0;
	localparam logic [3:0] ADDR_UNUSED = 4'd8;
	localparam logic [32:0] RADIUS_RESET = 33'd6371000000;
	localparam logic [32:0] RADIUS_MAX = 33'h1FFFFFFFF;

	typedef struct packed {
		logic        sel;
		logic [31:0] lat;
		logic [31:0] lon;
	} fix_t;

	typedef struct packed {
		logic [33:0] cx;
		logic [33:0] cy;
		logic [33:0] cz;
		logic [31:0] hdg;
	} centre_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic antenna_select = 1'b0;
	logic signed [31:0] latitude = '0;
	logic signed [31:0] longitude = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [33:0] center_x, center_y, center_z;
	logic signed [31:0] heading;

	dual_antenna_heading_center_top #(.CORDIC_STEPS(STEPS)) uut (.*);

	always #6 clk = ~clk;

	// Arctangent of 2^-i as a binary angle; the tail beyond step 30 is zero.
	longint arctan_lut [STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	fix_t    fix_queue[$];
	centre_t centre_queue[$];
	longint  pos_mm [2][3];
	logic [32:0] radius_mm;
	int fails = 0;
	int idle_cycles = 0;

	function automatic longint clamp_unit(input longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	// Rotation-mode sine and cosine in Q30. Angles in the left half plane are
	// turned through half a circle first and the results negated afterwards.
	task automatic sin_cos(input logic [31:0] ang, output longint s, output longint c);
		logic flip;
		longint x, y, z, tx, ty;
		flip = ang[30] ^ ang[31];
		if (flip) ang = ang + 32'h80000000;
		z = longint'(signed'(ang));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			tx = y >>> i;
			ty = x >>> i;
			if (z >= 0) begin
				x -= tx; y += ty; z -= arctan_lut[i];
			end else begin
				x += tx; y -= ty; z += arctan_lut[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = clamp_unit(x);
		s = clamp_unit(y);
	endtask

	// Vectoring-mode angle of the baseline; the first argument is the
	// vertical component, so heading is atan2(dx, dy).
	function automatic logic [31:0] baseline_angle(input longint ya, input longint xa);
		longint x, y, z, tx, ty;
		if (xa == 0 && ya == 0) return '0;
		x = xa * 64'sd16777216;
		y = ya * 64'sd16777216;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd2147483648;
		end
		for (int i = 0; i < STEPS; i++) begin
			tx = y >>> i;
			ty = x >>> i;
			if (y < 0) begin
				x -= tx; y += ty; z -= arctan_lut[i];
			end else begin
				x += tx; y -= ty; z += arctan_lut[i];
			end
		end
		return z[31:0];
	endfunction

	task automatic predict_centre(input fix_t f);
		longint slat, clat, slon, clon, rad, px, py;
		centre_t r;
		sin_cos(f.lat, slat, clat);
		sin_cos(f.lon, slon, clon);
		rad = longint'({31'd0, radius_mm});
		px = clamp_unit((clat * clon + 64'sd536870912) >>> 30);
		py = clamp_unit((clat * slon + 64'sd536870912) >>> 30);
		pos_mm[f.sel][0] = (rad * px + 64'sd536870912) >>> 30;
		pos_mm[f.sel][1] = (rad * py + 64'sd536870912) >>> 30;
		pos_mm[f.sel][2] = (rad * slat + 64'sd536870912) >>> 30;
		r.cx = 34'((pos_mm[0][0] + pos_mm[1][0]) >>> 1);
		r.cy = 34'((pos_mm[0][1] + pos_mm[1][1]) >>> 1);
		r.cz = 34'((pos_mm[0][2] + pos_mm[1][2]) >>> 1);
		r.hdg = baseline_angle(pos_mm[1][0] - pos_mm[0][0], pos_mm[1][1] - pos_mm[0][1]);
		centre_queue.push_back(r);
	endtask

	// Driver: bursts of random length separated by random gaps. A held
	// transaction keeps its payload until the block takes it.
	fix_t cur_fix;
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				predict_centre(cur_fix);
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (fix_queue.size() > 0) begin
					cur_fix = fix_queue.pop_front();
					antenna_select <= cur_fix.sel;
					latitude <= cur_fix.lat;
					longitude <= cur_fix.lon;
					busy = 1'b1;
					if (burst_left == 0) burst_left = $urandom_range(1, 8);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
				end
			end
			in_valid <= busy;
		end
	end

	// Monitor: the stall pattern switches between none, random and long runs.
	int stall_mode = 0;
	int stall_run = 0;
	always @(posedge clk or negedge arst_n) begin
		centre_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (centre_queue.size() == 0) begin
					$error("output transaction with nothing expected");
					fails++;
				end else begin
					e = centre_queue.pop_front();
					if (center_x !== e.cx) begin
						$error("center_x expected %0d got %0d", $signed(e.cx), center_x);
						fails++;
					end
					if (center_y !== e.cy) begin
						$error("center_y expected %0d got %0d", $signed(e.cy), center_y);
						fails++;
					end
					if (center_z !== e.cz) begin
						$error("center_z expected %0d got %0d", $signed(e.cz), center_z);
						fails++;
					end
					if (heading !== e.hdg) begin
						$error("heading expected %0d got %0d", $signed(e.hdg), heading);
						fails++;
					end
				end
			end
			if (stall_run == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_run = $urandom_range(50, 600);
			end
			stall_run--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= $urandom_range(0, 1);
				default: out_stall <= ($urandom_range(0, 15) < 13);
			endcase
		end
	end

	// Watchdog on cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles = 0;
		else if (fix_queue.size() > 0 || centre_queue.size() > 0 || in_valid)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("dual_antenna_heading_center_top test failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_RADIUS) radius_mm = data[32:0];
	endtask

	// Wait until every queued fix is taken and every result checked, then
	// give the block its full latency to settle.
	task automatic drain();
		while (fix_queue.size() > 0 || centre_queue.size() > 0 || in_valid)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic queue_fix(input logic sel, input logic [31:0] lat, input logic [31:0] lon);
		fix_t f;
		f.sel = sel;
		f.lat = lat;
		f.lon = lon;
		fix_queue.push_back(f);
	endtask

	// Mostly random fixes; some pairs sit close together for short baselines.
	task automatic queue_random(input int n);
		logic [31:0] lat, lon;
		for (int i = 0; i < n; i++) begin
			lat = $urandom;
			lon = $urandom;
			if ($urandom_range(0, 3) == 0) begin
				queue_fix(1'b0, lat, lon);
				queue_fix(1'b1, lat + $urandom_range(0, 2000), lon - $urandom_range(0, 2000));
				i++;
			end else begin
				queue_fix($urandom_range(0, 1), lat, lon);
			end
		end
	endtask

	initial begin
		radius_mm = RADIUS_RESET;
		for (int a = 0; a < 2; a++)
			for (int k = 0; k < 3; k++)
				pos_mm[a][k] = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: one antenna alone against the origin, the poles and
		// the angle extremes, a zero baseline, and a baseline pointing at
		// exactly half a circle of heading.
		queue_fix(1'b0, 32'h0000_0000, 32'h0000_0000);
		queue_fix(1'b1, 32'h4000_0000, 32'h7FFF_FFFF);
		queue_fix(1'b1, 32'hC000_0000, 32'h8000_0000);
		queue_fix(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_fix(1'b1, 32'h8000_0000, 32'h4000_0000);
		queue_fix(1'b0, 32'h5000_0000, 32'hB000_0000);
		queue_fix(1'b0, 32'h1234_5678, 32'h8765_4321);
		queue_fix(1'b1, 32'h1234_5678, 32'h8765_4321);
		queue_fix(1'b0, 32'h0000_0000, 32'h4000_0000);
		queue_fix(1'b1, 32'h0000_0000, 32'hC000_0000);
		queue_fix(1'b1, 32'h0000_0000, 32'h8000_0000);
		queue_fix(1'b0, 32'hFFFF_FFFF, 32'h0000_0001);
		drain();

		// Radius of zero, written with stray upper bits that must be dropped.
		reg_write(ADDR_RADIUS, 64'hFFFF_FFFE_0000_0000);
		reg_write(ADDR_UNUSED, 64'h0000_0000_0000_1234);
		queue_fix(1'b0, 32'h2000_0000, 32'h1000_0000);
		queue_random(60);
		drain();

		reg_write(ADDR_RADIUS, {31'd0, RADIUS_MAX});
		queue_fix(1'b1, 32'h4000_0000, 32'h0000_0000);
		queue_fix(1'b0, 32'hC000_0000, 32'h0000_0000);
		queue_random(200);
		drain();

		reg_write(ADDR_RADIUS, {$urandom, $urandom});
		queue_random(300);
		drain();

		reg_write(ADDR_RADIUS, {31'd0, RADIUS_RESET});
		queue_random(440);
		drain();

		if (fails == 0)
			$display("dual_antenna_heading_center_top test passed");
		else
			$display("dual_antenna_heading_center_top test failed");
		$finish;
	end

endmodule
